[sv/amt_pkg.sv]
package amt_pkg;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int OFFSET_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 2'd2;

	localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
	localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
	localparam logic [OFFSET_W-1:0] RESET_OFFSET = 8'd10;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_in;
	} in_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last_of_frame;
	} out_req_t;

endpackage

[sv/amt_line_store.sv]
// Pixel line store: 2*HALF_WINDOW+1 rows. Write port reads the old entry first.
module amt_line_store #(
	parameter int HALF_WINDOW = 10,
	parameter int MAX_WIDTH   = 1024
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [$clog2(2*HALF_WINDOW+1)-1:0]    wr_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
	input  logic [amt_pkg::PIX_W-1:0]             wr_data,
	output logic [amt_pkg::PIX_W-1:0]             old_data,
	input  logic                                  rd_en,
	input  logic [$clog2(2*HALF_WINDOW+1)-1:0]    rd_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0]          rd_col,
	output logic [amt_pkg::PIX_W-1:0]             rd_data
);
	localparam int SIDE   = 2 * HALF_WINDOW + 1;
	localparam int DEPTH  = SIDE * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [amt_pkg::PIX_W-1:0] line_mem_q [DEPTH];
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         rd_addr;
	logic [amt_pkg::PIX_W-1:0] old_q;
	logic [amt_pkg::PIX_W-1:0] rd_q;

	assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wr_col);
	assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			old_q               <= line_mem_q[wr_addr];
			line_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= line_mem_q[rd_addr];
		end
	end

	assign old_data = old_q;
	assign rd_data  = rd_q;
endmodule

[sv/amt_window_cell.sv]
// One column-sum cell of the horizontal window chain.
module amt_window_cell #(
	parameter int SUM_W = 13
) (
	input  logic             clk,
	input  logic             shift,
	input  logic [SUM_W-1:0] d,
	output logic [SUM_W-1:0] q
);
	logic [SUM_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;
endmodule

[sv/adaptive_mean_threshold_unit.sv]
// Adaptive mean threshold over a square (2*HALF_WINDOW+1) box window. Pixels
// arrive in raster order, one request per cycle unless stalled; each output
// pixel becomes 0 when pixel + offset is below the floor mean of its centred
// window, else 255, and pixels whose window leaves the frame pass through
// unchanged. An output appears when the last pixel of its window is taken,
// so the output stream trails the input by HALF_WINDOW*width+HALF_WINDOW
// positions; after a full frame, drain requests (kind=1) push out the tail
// one pixel each, and a drain with nothing pending gives no result. The unit
// takes one request every cycle unless stalled, the pace being set by the
// single write/read port pair of the line store and the column-sum memory.
// Each column keeps a running vertical sum in a memory; the last
// 2*HALF_WINDOW+1 column sums shift through a chain of cells and give the
// window sum with one add and one subtract per pixel. The mean comes from a
// multiply by a fixed reciprocal. Line store and column sums need no
// clearing pass after reset: the first row of a frame restarts each column
// sum. Geometry is clamped to [2*HALF_WINDOW+1, MAX_WIDTH] x
// [2*HALF_WINDOW+1, 4096] and is only to be changed between frames.
module adaptive_mean_threshold_unit #(
	parameter int HALF_WINDOW = 10,
	parameter int MAX_WIDTH   = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  amt_pkg::in_req_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output amt_pkg::out_req_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [amt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int SIDE    = 2 * HALF_WINDOW + 1;
	localparam int SLOT_W  = $clog2(SIDE);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W   = amt_pkg::HEIGHT_W;
	localparam int CS_W    = $clog2(SIDE * 255 + 1);
	localparam int AREA    = SIDE * SIDE;
	localparam int AREA_W  = $clog2(AREA);
	localparam int SUM_W   = $clog2(AREA * 255 + 1);
	localparam int K_SH    = SUM_W + AREA_W;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << K_SH) + 64'(AREA) - 64'd1) / 64'(AREA);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int PW = amt_pkg::PIX_W;

	// ---------------- configuration ----------------
	logic [amt_pkg::WIDTH_W-1:0]  raw_w_q;
	logic [amt_pkg::HEIGHT_W-1:0] raw_h_q;
	logic [amt_pkg::OFFSET_W-1:0] offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_w_q  <= amt_pkg::RESET_WIDTH;
			raw_h_q  <= amt_pkg::RESET_HEIGHT;
			offset_q <= amt_pkg::RESET_OFFSET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				amt_pkg::CFG_IMAGE_WIDTH:  raw_w_q  <= cfg_data[amt_pkg::WIDTH_W-1:0];
				amt_pkg::CFG_IMAGE_HEIGHT: raw_h_q  <= cfg_data[amt_pkg::HEIGHT_W-1:0];
				amt_pkg::CFG_OFFSET:       offset_q <= cfg_data[amt_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [WCNT_W-1:0] eff_w;
	logic [ROW_W-1:0]  eff_h;

	always_comb begin
		if (int'(raw_w_q) < SIDE)           eff_w = WCNT_W'(SIDE);
		else if (int'(raw_w_q) > MAX_WIDTH) eff_w = WCNT_W'(MAX_WIDTH);
		else                                eff_w = WCNT_W'(raw_w_q);
		if (int'(raw_h_q) < SIDE)                    eff_h = ROW_W'(SIDE);
		else if (int'(raw_h_q) > amt_pkg::MAX_HEIGHT) eff_h = ROW_W'(amt_pkg::MAX_HEIGHT);
		else                                          eff_h = raw_h_q;
	end

	// ---------------- handshake / stage enables ----------------
	logic v_s1, emit_s2, emit_s3, out_valid_q;
	logic en1, en2, en3, en_out, in_fire;

	assign en_out   = !out_valid_q || !out_stall;
	assign en3      = !emit_s3 || en_out;
	assign en2      = !emit_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign in_fire  = in_valid && en1;

	// ---------------- stage 0: positions ----------------
	logic [ROW_W-1:0]  in_row_q,  out_row_q;
	logic [WCNT_W-1:0] in_col_q,  out_col_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;

	logic is_pix, frame_start, out_zero, want, in_range, emit0, win0, last0;
	logic col_wrap_in, row_wrap_in, col_wrap_out;

	always_comb begin
		is_pix      = (in_data.kind == amt_pkg::KIND_PIXEL);
		frame_start = (in_row_q == '0) && (in_col_q == '0);
		out_zero    = (out_row_q == '0) && (out_col_q == '0);
		if (is_pix)
			want = (in_row_q > ROW_W'(HALF_WINDOW)) ||
				((in_row_q == ROW_W'(HALF_WINDOW)) && (in_col_q >= WCNT_W'(HALF_WINDOW)));
		else
			want = frame_start && !out_zero;
		in_range = (out_row_q < eff_h) && (out_col_q < eff_w);
		emit0    = want && in_range;
		last0    = (out_row_q == eff_h - 1'b1) && (out_col_q == eff_w - 1'b1);
		// centre away from every frame edge: thresholded, else passed through
		win0 = (out_row_q >= ROW_W'(HALF_WINDOW)) &&
			(({1'b0, out_row_q} + (ROW_W + 1)'(HALF_WINDOW)) < {1'b0, eff_h}) &&
			(out_col_q >= WCNT_W'(HALF_WINDOW)) &&
			(({1'b0, out_col_q} + (WCNT_W + 1)'(HALF_WINDOW)) < {1'b0, eff_w});
		col_wrap_in  = (in_col_q + 1'b1) == eff_w;
		row_wrap_in  = (in_row_q + 1'b1) == eff_h;
		col_wrap_out = (out_col_q + 1'b1) == eff_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
		end else if (in_fire) begin
			if (is_pix) begin
				if (col_wrap_in) begin
					in_col_q <= '0;
					if (row_wrap_in) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
					end else begin
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (in_slot_q == SLOT_W'(SIDE - 1)) ? '0 : in_slot_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			// output position: restart on a new frame, after the last pixel, or on a stale position
			if ((is_pix && frame_start) || (want && !in_range) || (emit0 && last0)) begin
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_slot_q <= '0;
			end else if (emit0) begin
				if (col_wrap_out) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + 1'b1;
					out_slot_q <= (out_slot_q == SLOT_W'(SIDE - 1)) ? '0 : out_slot_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// ---------------- line store ----------------
	logic [PW-1:0] old_s1, cen_s1;

	amt_line_store #(.HALF_WINDOW(HALF_WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_store (
		.clk      (clk),
		.wr_en    (in_fire && is_pix),
		.wr_slot  (in_slot_q),
		.wr_col   (in_col_q[COL_W-1:0]),
		.wr_data  (in_data.pixel_in),
		.old_data (old_s1),
		.rd_en    (in_fire),
		.rd_slot  (out_slot_q),
		.rd_col   (out_col_q[COL_W-1:0]),
		.rd_data  (cen_s1)
	);

	// ---------------- stage 1: column sums ----------------
	logic [CS_W-1:0]   col_sum_mem_q [MAX_WIDTH];
	logic [CS_W-1:0]   cs_rd_s1;
	logic [CS_W-1:0]   cs_new;
	logic              pix_v_s1, first_s1, sub_s1, emit_s1, win_s1, last_s1;
	logic [PW-1:0]     pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              col_full_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_fire) begin
			pix_v_s1    <= is_pix;
			pix_s1      <= in_data.pixel_in;
			col_s1      <= in_col_q[COL_W-1:0];
			col_full_s1 <= (in_col_q >= WCNT_W'(SIDE));
			first_s1    <= (in_row_q == '0);
			sub_s1      <= (in_row_q >= ROW_W'(SIDE));
			emit_s1     <= emit0;
			win_s1      <= win0;
			last_s1     <= last0;
		end
		if (in_fire && is_pix) begin
			cs_rd_s1 <= col_sum_mem_q[in_col_q[COL_W-1:0]];
		end
		if (en2 && v_s1 && pix_v_s1) begin
			col_sum_mem_q[col_s1] <= cs_new;
		end
	end

	// vertical sum of this column over the last SIDE rows
	assign cs_new = first_s1 ? CS_W'(pix_s1)
		: cs_rd_s1 + CS_W'(pix_s1) - (sub_s1 ? CS_W'(old_s1) : CS_W'(0));

	// ---------------- chain of column-sum cells ----------------
	logic            shift;
	logic [CS_W-1:0] chain [SIDE+1];

	assign shift    = en2 && v_s1 && pix_v_s1;
	assign chain[0] = cs_new;

	for (genvar g = 0; g < SIDE; g++) begin : g_cell
		amt_window_cell #(.SUM_W(CS_W)) u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (chain[g]),
			.q     (chain[g+1])
		);
	end

	// running window sum: add the new column, drop the one SIDE back
	logic [SUM_W-1:0] hsum_q, hsum_next;
	assign hsum_next = (col_s1 == '0) ? SUM_W'(cs_new)
		: hsum_q + SUM_W'(cs_new) - (col_full_s1 ? SUM_W'(chain[SIDE]) : SUM_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= '0;
		end else if (shift) begin
			hsum_q <= hsum_next;
		end
	end

	// ---------------- stage 2 / 3: mean and compare ----------------
	logic              win_s2, last_s2, win_s3, last_s3;
	logic [PW-1:0]     cen_s2, cen_s3;
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2     <= 1'b0;
			emit_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en2)    emit_s2     <= v_s1 && emit_s1;
			if (en3)    emit_s3     <= emit_s2;
			if (en_out) out_valid_q <= emit_s3;
		end
	end

	logic [PW-1:0]      mean_s3;
	logic               dark_s3;
	amt_pkg::out_req_t  out_q;

	assign mean_s3 = prod_s3[K_SH +: PW];
	assign dark_s3 = ({1'b0, cen_s3} + {1'b0, offset_q}) < {1'b0, mean_s3};

	always_ff @(posedge clk) begin
		if (en2) begin
			win_s2  <= win_s1;
			last_s2 <= last_s1;
			cen_s2  <= cen_s1;
		end
		if (en3) begin
			win_s3  <= win_s2;
			last_s3 <= last_s2;
			cen_s3  <= cen_s2;
			prod_s3 <= PROD_W'(hsum_q) * PROD_W'(RECIP);
		end
		if (en_out) begin
			out_q.pixel_out     <= win_s3 ? (dark_s3 ? amt_pkg::PIX_BLACK : amt_pkg::PIX_WHITE)
				: cen_s3;
			out_q.last_of_frame <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
